[rtl/core/fla_pkg.sv]
`timescale 1ns / 1ps

package fla_pkg;

    // fixed field widths
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned OFFSET_W  = 20;
    localparam int unsigned CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_WALK = 4'b1000
    } t_state;

    // operands for the shared add/compare unit
    typedef struct packed {
        logic [IDX_W-1:0] add_a;
        logic [IDX_W-1:0] add_b;
        logic [IDX_W-1:0] cmp_a;
        logic [IDX_W-1:0] cmp_b;
    } t_step_req;

    // results of the shared add/compare unit
    typedef struct packed {
        logic [IDX_W-1:0] sum;
        logic             eq;
        logic             lt;
    } t_step_res;

endpackage

[rtl/core/fla_step_unit.sv]
`timescale 1ns / 1ps

module fla_step_unit (
    input  fla_pkg::t_step_req i_req,
    output fla_pkg::t_step_res o_res
);

    // one 8-bit adder and one magnitude compare, shared by allocate, free, reset and query
    always_comb begin
        o_res.sum = i_req.add_a + i_req.add_b;
        o_res.eq  = (i_req.cmp_a == i_req.cmp_b);
        o_res.lt  = (i_req.cmp_a < i_req.cmp_b);
    end

endmodule

[rtl/core/fla_link_store.sv]
`timescale 1ns / 1ps

module fla_link_store #(
    parameter int unsigned DEPTH = 255
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [fla_pkg::IDX_W-1:0] i_rd_addr,
    output logic [fla_pkg::IDX_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [fla_pkg::IDX_W-1:0] i_wr_addr,
    input  logic [fla_pkg::IDX_W-1:0] i_wr_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [fla_pkg::IDX_W-1:0] r_mem [DEPTH];
    logic [fla_pkg::IDX_W-1:0] r_rd_data;
    logic                      r_rd_oob;
    logic                      rd_in_range;
    logic                      wr_in_range;

    assign rd_in_range = (i_rd_addr < fla_pkg::IDX_W'(DEPTH));
    assign wr_in_range = (i_wr_addr < fla_pkg::IDX_W'(DEPTH));

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
    end

    // registered read port, links past the store read as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_oob <= !rd_in_range;
            if (rd_in_range) begin
                r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_oob ? '0 : r_rd_data;

endmodule

[rtl/core/free_list_block_allocator_unit.sv]
`timescale 1ns / 1ps

// Free-list allocator for up to MAX_BLOCKS equal-sized blocks. Links live in a
// single-port-read store; a head register and a free count go with them. Each
// command gives one result. Allocate, free, release and unused codes pass from
// idle to the execute state, which holds while a full output register waits.
// Reset list writes one link per cycle, n = min(num_blocks, MAX_BLOCKS) links.
// Query follows at most free_count links, one per cycle, through the store's
// registered read port. The block takes no new command while one is at work,
// but it does take one while a finished result still waits in the output
// register. Configuration writes are taken at any time and are meant for idle.
module free_list_block_allocator_unit #(
    parameter int unsigned MAX_BLOCKS = 255
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [fla_pkg::CMD_W-1:0]        i_cmd,
    input  logic [fla_pkg::IDX_W-1:0]        i_block_index,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fla_pkg::STATUS_W-1:0]     o_status,
    output logic [fla_pkg::IDX_W-1:0]        o_result_index,
    output logic [fla_pkg::OFFSET_W-1:0]     o_byte_offset,
    output logic [fla_pkg::IDX_W-1:0]        o_free_count,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fla_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fla_pkg::SIZE_W-1:0]       i_cfg_data
);

    localparam int unsigned PROD_W = fla_pkg::IDX_W + fla_pkg::SIZE_W;
    localparam logic [fla_pkg::IDX_W-1:0] MAX_IDX = fla_pkg::IDX_W'(MAX_BLOCKS);

    fla_pkg::t_state r_state, n_state;

    logic [fla_pkg::IDX_W-1:0]    r_head, n_head;
    logic [fla_pkg::IDX_W-1:0]    r_count, n_count;
    logic [fla_pkg::IDX_W-1:0]    r_fill, n_fill;
    logic [fla_pkg::IDX_W-1:0]    r_left, n_left;
    logic                         r_first, n_first;
    logic [fla_pkg::CMD_W-1:0]    r_cmd;
    logic [fla_pkg::IDX_W-1:0]    r_idx;
    logic [fla_pkg::IDX_W-1:0]    r_num_blocks;
    logic [fla_pkg::SIZE_W-1:0]   r_block_size;

    logic                         r_out_valid;
    logic [fla_pkg::STATUS_W-1:0] r_status;
    logic [fla_pkg::IDX_W-1:0]    r_result_index;
    logic [fla_pkg::OFFSET_W-1:0] r_byte_offset;
    logic [fla_pkg::IDX_W-1:0]    r_free_count;

    logic                         in_xfer;
    logic                         out_free;
    logic                         commit;
    logic [fla_pkg::STATUS_W-1:0] res_status;
    logic [fla_pkg::IDX_W-1:0]    res_index;
    logic [fla_pkg::OFFSET_W-1:0] res_offset;
    logic [fla_pkg::IDX_W-1:0]    n_eff;
    logic [fla_pkg::IDX_W-1:0]    walk_cur;
    logic [PROD_W-1:0]            prod;

    logic                         rd_en;
    logic [fla_pkg::IDX_W-1:0]    rd_addr;
    logic [fla_pkg::IDX_W-1:0]    rd_data;
    logic                         wr_en;
    logic [fla_pkg::IDX_W-1:0]    wr_addr;
    logic [fla_pkg::IDX_W-1:0]    wr_data;

    fla_pkg::t_step_req step_req;
    fla_pkg::t_step_res step_res;

    assign o_ready     = (r_state == fla_pkg::S_IDLE);
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;

    // blocks in use, capped at the store depth
    assign n_eff = (r_num_blocks > MAX_IDX) ? MAX_IDX : r_num_blocks;

    // offset of the block at the head
    assign prod = PROD_W'(r_head) * PROD_W'(r_block_size);

    // current position of a query walk
    assign walk_cur = r_first ? r_head : rd_data;

    fla_step_unit u_step (
        .i_req (step_req),
        .o_res (step_res)
    );

    fla_link_store #(
        .DEPTH (MAX_BLOCKS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_fill     = r_fill;
        n_left     = r_left;
        n_first    = r_first;
        step_req   = '0;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        wr_en      = 1'b0;
        wr_addr    = r_fill;
        wr_data    = step_res.sum;
        commit     = 1'b0;
        res_status = fla_pkg::ST_OK;
        res_index  = '0;
        res_offset = '0;

        unique case (r_state)
            fla_pkg::S_IDLE: begin
                if (in_xfer) begin
                    // fetch the head link for a possible allocate
                    rd_en = 1'b1;
                    priority if (i_cmd == fla_pkg::CMD_RESET) begin
                        n_state = fla_pkg::S_FILL;
                        n_fill  = '0;
                    end else if (i_cmd == fla_pkg::CMD_QUERY) begin
                        n_state = fla_pkg::S_WALK;
                        n_first = 1'b1;
                        n_left  = r_count;
                    end else begin
                        n_state = fla_pkg::S_EXEC;
                    end
                end
            end

            fla_pkg::S_EXEC: begin
                commit = out_free;
                if (out_free) begin
                    n_state = fla_pkg::S_IDLE;
                end
                unique case (r_cmd)
                    fla_pkg::CMD_ALLOC: begin
                        step_req.add_a = r_count;
                        step_req.add_b = '1;
                        if (r_count == '0) begin
                            res_status = fla_pkg::ST_NONE;
                        end else begin
                            res_index  = r_head;
                            res_offset = prod[fla_pkg::OFFSET_W-1:0];
                            if (out_free) begin
                                n_head  = rd_data;
                                n_count = step_res.sum;
                            end
                        end
                    end
                    fla_pkg::CMD_FREE: begin
                        step_req.add_a = r_count;
                        step_req.add_b = fla_pkg::IDX_W'(1);
                        step_req.cmp_a = r_idx;
                        step_req.cmp_b = n_eff;
                        if (step_res.lt) begin
                            wr_addr = r_idx;
                            wr_data = r_head;
                            if (out_free) begin
                                wr_en   = 1'b1;
                                n_head  = r_idx;
                                n_count = step_res.sum;
                            end
                        end else begin
                            res_status = fla_pkg::ST_RANGE;
                        end
                    end
                    fla_pkg::CMD_RELEASE: begin
                        if (out_free) begin
                            n_head  = '0;
                            n_count = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            fla_pkg::S_FILL: begin
                // link block i to block i + 1, one entry per cycle
                step_req.add_a = r_fill;
                step_req.add_b = fla_pkg::IDX_W'(1);
                step_req.cmp_a = r_fill;
                step_req.cmp_b = n_eff;
                if (step_res.lt) begin
                    wr_en  = 1'b1;
                    n_fill = step_res.sum;
                end else if (out_free) begin
                    commit  = 1'b1;
                    n_head  = '0;
                    n_count = n_eff;
                    n_state = fla_pkg::S_IDLE;
                end
            end

            fla_pkg::S_WALK: begin
                // follow one link per cycle, at most free_count entries
                step_req.add_a = r_left;
                step_req.add_b = '1;
                step_req.cmp_a = walk_cur;
                step_req.cmp_b = r_idx;
                if (r_left == '0 || step_res.eq) begin
                    res_status = (r_left == '0) ? fla_pkg::ST_NOT_FOUND : fla_pkg::ST_OK;
                    if (out_free) begin
                        commit  = 1'b1;
                        n_state = fla_pkg::S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = walk_cur;
                    n_left  = step_res.sum;
                    n_first = 1'b0;
                end
            end

            default: begin
                n_state = fla_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fla_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_fill  <= '0;
            r_left  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_first <= n_first;
        end
    end

    // command capture on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_cmd;
            r_idx <= i_block_index;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks <= fla_pkg::IDX_W'(255);
            r_block_size <= fla_pkg::SIZE_W'(16);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == fla_pkg::CFG_NUM_BLOCKS) begin
                r_num_blocks <= i_cfg_data[fla_pkg::IDX_W-1:0];
            end else if (i_cfg_index == fla_pkg::CFG_BLOCK_SIZE) begin
                r_block_size <= i_cfg_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_status       <= res_status;
            r_result_index <= res_index;
            r_byte_offset  <= res_offset;
            r_free_count   <= n_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_result_index = r_result_index;
    assign o_byte_offset  = r_byte_offset;
    assign o_free_count   = r_free_count;

endmodule
